// File: hdl/track_antenna_pointing_unit_defines.svh
// assertion macros for the antenna pointing unit
`ifndef TRACK_ANTENNA_POINTING_UNIT_DEFINES_SVH
`define TRACK_ANTENNA_POINTING_UNIT_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define TAP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pointing unit: same-cycle check failed");

// next-cycle implication, checked on aclk outside reset
`define TAP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pointing unit: next-cycle check failed");

`endif

// File: hdl/tap_pkg.sv
// shared types, constants and the arctangent table of the pointing unit
`default_nettype none
package tap_pkg;
    localparam int DATA_W        = 52;
    localparam int ACC_W         = 34;
    localparam int DOWN_W        = 48;
    localparam int ANGLE_W       = 16;
    localparam int GAIN_W        = 30;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_STAGES = 16;

    localparam logic signed [ACC_W-1:0] PI_UNITS = ACC_W'(64'sd2147483648);
    localparam logic [GAIN_W-1:0]       INV_GAIN = GAIN_W'(652032875);

    localparam logic SCAN_CONICAL = 1'b0;
    localparam logic SCAN_HBAR    = 1'b1;

    localparam logic [2:0] REG_AZ_LEFT  = 3'd0;
    localparam logic [2:0] REG_AZ_RIGHT = 3'd1;
    localparam logic [2:0] REG_EL_LOWER = 3'd2;
    localparam logic [2:0] REG_EL_UPPER = 3'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0]  x;
        logic signed [DATA_W-1:0]  y;
        logic signed [ACC_W-1:0]   acc;
        logic                      zero;
        logic                      present;
        logic signed [DOWN_W-1:0]  down;
        logic signed [ANGLE_W-1:0] az;
    } cordic_t;

    // rounded atan(2^-i) in units of pi/2^31
    function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return $signed({{(ACC_W-32){1'b0}}, v});
    endfunction
endpackage
`default_nettype wire

// File: hdl/track_antenna_pointing_unit.sv
// top level: antenna pointing at a track with azimuth and elevation limits
//
// input channel s_*: one request per track update (track flag, north/east/down
// offset in eighths of a metre, heading sine and cosine in Q1.15)
// result channel m_*: one result per request, in order: clamped azimuth and
// elevation as 16-bit binary angles, scan mode 0 conical, 1 horizontal bar
// configuration channel cfg_*: index 0..3 selects azimuth left, azimuth right,
// elevation lower, elevation upper limit; other indexes are ignored; always ready
// registers from acceptance to m_valid, in order: input products, heading
// rotation, azimuth cells, gain multiply, gain sum, elevation cells,
// round/clamp/output register; throughput: one request per cycle while
// m_ready is high, set by the one-cell-per-rotation chains
// every stage has its own valid bit and ready, so bubbles close up and new
// requests keep entering while a result waits at the output register
// when m_ready is low, the pipeline fills behind the held result and s_ready
// drops only once every stage is occupied
// reset (aresetn low, synchronous) empties the pipeline and restores the
// limits to -32768, 32767, -16384, 16384
`default_nettype none
`include "track_antenna_pointing_unit_defines.svh"
module track_antenna_pointing_unit
    import tap_pkg::*;
#(
    parameter int CORDIC_STAGES = tap_pkg::CORDIC_STAGES
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_track_present,
    input  wire logic signed [31:0]   s_rel_north,
    input  wire logic signed [31:0]   s_rel_east,
    input  wire logic signed [31:0]   s_rel_down,
    input  wire logic signed [15:0]   s_heading_sine,
    input  wire logic signed [15:0]   s_heading_cosine,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [15:0]        m_ref_azimuth,
    output logic signed [15:0]        m_ref_elevation,
    output logic                      m_scan_mode,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [15:0]          cfg_data
);
    localparam int PROD_W  = 48;
    localparam int SPLIT   = 26;
    localparam int HI_W    = DATA_W - SPLIT;
    localparam int SUM_W   = DATA_W + GAIN_W;
    localparam int SHORT_W = ACC_W - ANGLE_W;

    // limit registers
    logic signed [ANGLE_W-1:0] az_left_reg, az_right_reg, el_lower_reg, el_upper_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            az_left_reg  <= -16'sd32768;
            az_right_reg <= 16'sd32767;
            el_lower_reg <= -16'sd16384;
            el_upper_reg <= 16'sd16384;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_AZ_LEFT:  az_left_reg  <= cfg_data;
                REG_AZ_RIGHT: az_right_reg <= cfg_data;
                REG_EL_LOWER: el_lower_reg <= cfg_data;
                REG_EL_UPPER: el_upper_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // round half up to 16 bits and saturate
    function automatic logic signed [ANGLE_W-1:0] to_angle(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0]   t;
        logic signed [SHORT_W-1:0] s;
        t = a + ACC_W'(32768);
        s = SHORT_W'(t >>> ANGLE_W);
        if (s > SHORT_W'(32767)) begin
            return 16'sd32767;
        end else if (s < -SHORT_W'(32768)) begin
            return -16'sd32768;
        end
        return s[ANGLE_W-1:0];
    endfunction

    // stage 1: heading rotation products
    logic s1_valid_reg, s1_ready, s1_present_reg;
    logic signed [PROD_W-1:0] nc_reg, es_reg, ec_reg, ns_reg;
    logic signed [DOWN_W-1:0] s1_down_reg;
    // stage 2: rotated offset
    logic s2_valid_reg, s2_ready, s2_present_reg;
    logic signed [DATA_W-1:0] s2_x_reg, s2_y_reg;
    logic signed [DOWN_W-1:0] s2_down_reg;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_ready  = s1_ready;

    cordic_t az_in, az_out, el_in, el_out;
    logic az_in_ready, az_out_valid, el_in_ready, el_out_valid;
    logic s3_ready, s4_ready, s5_ready;

    assign s2_ready = !s2_valid_reg || az_in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_ready) s1_valid_reg <= s_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
        end
        if (s1_ready && s_valid) begin
            nc_reg         <= s_rel_north * s_heading_cosine;
            es_reg         <= s_rel_east * s_heading_sine;
            ec_reg         <= s_rel_east * s_heading_cosine;
            ns_reg         <= s_rel_north * s_heading_sine;
            // down scaled by 2^15, sign kept
            s1_down_reg    <= {s_rel_down[31], s_rel_down, 15'b0};
            s1_present_reg <= s_track_present;
        end
        if (s2_ready && s1_valid_reg) begin
            s2_x_reg       <= DATA_W'(nc_reg) + DATA_W'(es_reg);
            s2_y_reg       <= DATA_W'(ec_reg) - DATA_W'(ns_reg);
            s2_down_reg    <= s1_down_reg;
            s2_present_reg <= s1_present_reg;
        end
    end

    always_comb begin
        az_in         = '0;
        az_in.x       = s2_x_reg;
        az_in.y       = s2_y_reg;
        az_in.present = s2_present_reg;
        az_in.down    = s2_down_reg;
    end

    // azimuth and ground range
    tap_cordic_chain #(.STAGES(CORDIC_STAGES)) u_az_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid_reg),
        .in_ready  (az_in_ready),
        .in_data   (az_in),
        .out_valid (az_out_valid),
        .out_ready (s3_ready),
        .out_data  (az_out)
    );

    // stage 3: azimuth rounding and gain partial products
    logic s3_valid_reg, s3_present_reg;
    logic signed [ANGLE_W-1:0] s3_az_reg;
    logic signed [DOWN_W-1:0]  s3_down_reg;
    logic [HI_W+GAIN_W-1:0]    pa_reg;
    logic [SPLIT+GAIN_W-1:0]   pb_reg;
    logic [DATA_W-1:0]         gain_u;
    // stage 4: ground range
    logic s4_valid_reg, s4_present_reg;
    logic signed [ANGLE_W-1:0] s4_az_reg;
    logic signed [DOWN_W-1:0]  s4_down_reg;
    logic [DATA_W-1:0]         grng_reg;
    logic [SUM_W-1:0]          gain_sum;

    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s4_ready = !s4_valid_reg || el_in_ready;
    // a non-positive range, and the zero vector, give zero range
    assign gain_u = (az_out.zero || az_out.x[DATA_W-1] || az_out.x == '0)
                    ? '0 : DATA_W'(az_out.x);
    assign gain_sum = {pa_reg, {SPLIT{1'b0}}} + SUM_W'(pb_reg) + (SUM_W'(1) << (GAIN_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (s3_ready) s3_valid_reg <= az_out_valid;
            if (s4_ready) s4_valid_reg <= s3_valid_reg;
        end
        if (s3_ready && az_out_valid) begin
            s3_az_reg      <= az_out.zero ? '0 : to_angle(az_out.acc);
            pa_reg         <= gain_u[DATA_W-1:SPLIT] * INV_GAIN;
            pb_reg         <= gain_u[SPLIT-1:0] * INV_GAIN;
            s3_down_reg    <= az_out.down;
            s3_present_reg <= az_out.present;
        end
        if (s4_ready && s3_valid_reg) begin
            grng_reg       <= gain_sum[SUM_W-1:GAIN_W];
            s4_az_reg      <= s3_az_reg;
            s4_down_reg    <= s3_down_reg;
            s4_present_reg <= s3_present_reg;
        end
    end

    always_comb begin
        el_in         = '0;
        el_in.x       = $signed(grng_reg);
        el_in.y       = -DATA_W'(s4_down_reg);
        el_in.present = s4_present_reg;
        el_in.down    = s4_down_reg;
        el_in.az      = s4_az_reg;
    end

    // elevation above ground range
    tap_cordic_chain #(.STAGES(CORDIC_STAGES)) u_el_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s4_valid_reg),
        .in_ready  (el_in_ready),
        .in_data   (el_in),
        .out_valid (el_out_valid),
        .out_ready (s5_ready),
        .out_data  (el_out)
    );

    // stage 5: clamp to limits, output register
    logic signed [ANGLE_W-1:0] el_raw, az_lim, el_lim;
    logic m_valid_reg, m_scan_reg;
    logic signed [ANGLE_W-1:0] m_az_reg, m_el_reg;

    assign s5_ready = !m_valid_reg || m_ready;
    assign el_raw   = el_out.zero ? '0 : to_angle(el_out.acc);

    always_comb begin
        // lower bound checked first; crossed limits clamp values below it to it
        priority if (el_out.az < az_left_reg) begin
            az_lim = az_left_reg;
        end else if (el_out.az > az_right_reg) begin
            az_lim = az_right_reg;
        end else begin
            az_lim = el_out.az;
        end
        priority if (el_raw < el_lower_reg) begin
            el_lim = el_lower_reg;
        end else if (el_raw > el_upper_reg) begin
            el_lim = el_upper_reg;
        end else begin
            el_lim = el_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s5_ready) begin
            m_valid_reg <= el_out_valid;
        end
        if (s5_ready && el_out_valid) begin
            // no track: zero angles, search pattern
            m_az_reg   <= el_out.present ? az_lim : '0;
            m_el_reg   <= el_out.present ? el_lim : '0;
            m_scan_reg <= el_out.present ? SCAN_CONICAL : SCAN_HBAR;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_ref_azimuth   = m_az_reg;
    assign m_ref_elevation = m_el_reg;
    assign m_scan_mode     = m_scan_reg;

    `TAP_ASSERT_SAME(a_search_zero, m_valid && m_scan_mode == SCAN_HBAR,
        m_ref_azimuth == 16'sd0 && m_ref_elevation == 16'sd0)
    `TAP_ASSERT_SAME(a_az_in_limits,
        m_valid && m_scan_mode == SCAN_CONICAL && az_left_reg <= az_right_reg,
        m_ref_azimuth >= az_left_reg && m_ref_azimuth <= az_right_reg)
    `TAP_ASSERT_SAME(a_el_in_limits,
        m_valid && m_scan_mode == SCAN_CONICAL && el_lower_reg <= el_upper_reg,
        m_ref_elevation >= el_lower_reg && m_ref_elevation <= el_upper_reg)
    `TAP_ASSERT_NEXT(a_accept_enters, s_valid && s_ready, s1_valid_reg)
endmodule
`default_nettype wire

// File: hdl/tap_cordic_cell.sv
// one vectoring micro-rotation cell with its own pipeline register
`default_nettype none
module tap_cordic_cell
    import tap_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire cordic_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cordic_t      out_data
);
    localparam logic signed [ACC_W-1:0] ATAN = atan_entry(SHIFT);

    logic    valid_reg, valid_next;
    cordic_t data_reg, data_next;
    logic signed [DATA_W-1:0] dx, dy;

    assign in_ready = !valid_reg || out_ready;
    assign dx = in_data.y >>> SHIFT;
    assign dy = in_data.x >>> SHIFT;

    always_comb begin
        data_next = in_data;
        if (!in_data.y[DATA_W-1]) begin
            data_next.x   = in_data.x + dx;
            data_next.y   = in_data.y - dy;
            data_next.acc = in_data.acc + ATAN;
        end else begin
            data_next.x   = in_data.x - dx;
            data_next.y   = in_data.y + dy;
            data_next.acc = in_data.acc - ATAN;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

// File: hdl/tap_cordic_chain.sv
// quadrant pre-rotation followed by a row of cordic cells
`default_nettype none
module tap_cordic_chain
    import tap_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire cordic_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output cordic_t      out_data
);
    cordic_t pre;
    cordic_t link  [STAGES+1];
    logic    lvalid[STAGES+1];
    logic    lready[STAGES+1];

    // left half plane: negate and start from plus or minus pi
    always_comb begin
        pre      = in_data;
        pre.acc  = '0;
        pre.zero = (in_data.x == '0) && (in_data.y == '0);
        if (in_data.x[DATA_W-1]) begin
            pre.acc = in_data.y[DATA_W-1] ? -PI_UNITS : PI_UNITS;
            pre.x   = -in_data.x;
            pre.y   = -in_data.y;
        end
    end

    assign link[0]   = pre;
    assign lvalid[0] = in_valid;
    assign in_ready  = lready[0];

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        tap_cordic_cell #(.SHIFT(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (lvalid[i]),
            .in_ready  (lready[i]),
            .in_data   (link[i]),
            .out_valid (lvalid[i+1]),
            .out_ready (lready[i+1]),
            .out_data  (link[i+1])
        );
    end

    assign lready[STAGES] = out_ready;
    assign out_valid      = lvalid[STAGES];
    assign out_data       = link[STAGES];
endmodule
`default_nettype wire
